// File: rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  // Storage geometry
  localparam int Depth     = 16;
  localparam int DataWidth = 32;
  localparam int PtrW      = $clog2(Depth);
  localparam int OccW      = $clog2(Depth + 1);
  localparam int CountW    = 5;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [OccW-1:0] occ_t;
  typedef logic [DataWidth-1:0] word_t;

  // Operation codes
  localparam logic [2:0] ModePushFront = 3'd0;
  localparam logic [2:0] ModePushRear  = 3'd1;
  localparam logic [2:0] ModePopFront  = 3'd2;
  localparam logic [2:0] ModePopRear   = 3'd3;
  localparam logic [2:0] ModeQuery     = 3'd4;

  // Status codes
  localparam logic [1:0] StatDone      = 2'd0;
  localparam logic [1:0] StatOverflow  = 2'd1;
  localparam logic [1:0] StatUnderflow = 2'd2;

  localparam logic signed [31:0] EmptyMark = -32'sd999;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
    logic [CountW-1:0]  count;
  } cdq_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StRead,
    StResp
  } state_e;

  typedef struct packed {
    logic capture;   // latch the accepted beat
    logic exec;      // update pointers, write the store
    logic load_out;  // load the result register
  } cdq_cmd_t;

  // Keep the low DataWidth bits of an incoming value
  function automatic word_t to_store(logic signed [31:0] v);
    logic [63:0] wide;
    wide = 64'(unsigned'(v));
    return wide[DataWidth-1:0];
  endfunction

  // Sign-extend a stored word into the 32-bit result field
  function automatic logic signed [31:0] to_result(word_t w);
    logic signed [63:0] wide;
    wide = 64'(signed'(w));
    return wide[31:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/circular_deque_top.sv
// Channel   Dir  Handshake              Beat
// -------   ---  ---------------------  ---------------------------------------
// in        in   in_valid_i/in_stall_o   cdq_in_t: mode, value
// out       out  out_valid_o/out_stall_i cdq_out_t: status, front/rear, flags, count
//
// An item passes four steps: accept, pointer update with store write, store
// read, result load. The two-port store read is registered, which sets the
// read cycle. One item is in flight; the next beat is taken while the
// previous result still waits in the output register.
// Reset clears the pointers, the occupancy, the status, the sequencer state
// and the result valid flag; the store holds no reset value.
// A stalled result holds and blocks only the load step.
`default_nettype none

module circular_deque_top import cdq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire cdq_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output cdq_out_t     out_data_o
);

  // Commands from the sequencer to the pointer and store datapath
  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Head, tail and occupancy live here together with the store
  cdq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // An accepted beat closes the input until its result is loaded
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // An empty result carries the empty mark and a zero count
  a_empty_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.count == '0 && out_data_o.front_value == EmptyMark &&
      out_data_o.rear_value == EmptyMark)
    else $error("empty result without empty mark");

  // Overflow only happens when full, underflow only when empty
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatOverflow |-> out_data_o.is_full)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatUnderflow |-> out_data_o.is_empty)
    else $error("underflow reported while not empty");

endmodule

`default_nettype wire

// File: rtl/cdq_ram.sv
`default_nettype none

module cdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: rtl/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output cdq_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    // drop the result once it is taken
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StRead;
      end
      StRead: begin
        state_d = StResp;
      end
      StResp: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/cdq_dpath.sv
`default_nettype none

module cdq_dpath import cdq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cdq_cmd_t cmd_i,
  input  wire cdq_in_t  in_data_i,
  output cdq_out_t      out_data_o
);

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(Depth - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? ptr_t'(Depth - 1) : ptr_t'(p - 1'b1);
  endfunction

  logic [2:0] mode_q;
  word_t      wdata_q;
  ptr_t       head_q, head_d;
  ptr_t       tail_q, tail_d;
  occ_t       occ_q, occ_d;
  logic [1:0] status_q, status_d;
  logic       we;
  ptr_t       waddr;
  word_t      rdata_front, rdata_rear;
  logic       is_empty, is_full;
  cdq_out_t   out_q, out_d;

  assign is_empty = (occ_q == '0);
  assign is_full  = (occ_q == occ_t'(Depth));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= in_data_i.mode;
      wdata_q <= to_store(in_data_i.value);
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      status_q <= StatDone;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = head_q;
    if (cmd_i.exec) begin
      status_d = StatDone;
      unique case (mode_q)
        ModePushFront, ModePushRear: begin
          priority if (is_full) begin
            status_d = StatOverflow;
          end else if (is_empty) begin
            // first element always lands at entry zero
            head_d = '0;
            tail_d = '0;
            waddr  = '0;
            we     = 1'b1;
            occ_d  = occ_t'(1);
          end else if (mode_q == ModePushFront) begin
            head_d = ptr_dec(head_q);
            waddr  = head_d;
            we     = 1'b1;
            occ_d  = occ_t'(occ_q + 1'b1);
          end else begin
            tail_d = ptr_inc(tail_q);
            waddr  = tail_d;
            we     = 1'b1;
            occ_d  = occ_t'(occ_q + 1'b1);
          end
        end
        ModePopFront, ModePopRear: begin
          priority if (is_empty) begin
            status_d = StatUnderflow;
          end else if (occ_q == occ_t'(1)) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
          end else if (mode_q == ModePopFront) begin
            head_d = ptr_inc(head_q);
            occ_d  = occ_t'(occ_q - 1'b1);
          end else begin
            tail_d = ptr_dec(tail_q);
            occ_d  = occ_t'(occ_q - 1'b1);
          end
        end
        default: begin
          // query and unused codes leave the deque alone
        end
      endcase
    end
  end

  cdq_ram #(
    .Width (DataWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata_q),
    .raddr_a_i (head_q),
    .raddr_b_i (tail_q),
    .rdata_a_o (rdata_front),
    .rdata_b_o (rdata_rear)
  );

  always_comb begin
    out_d.status      = status_q;
    out_d.front_value = is_empty ? EmptyMark : to_result(rdata_front);
    out_d.rear_value  = is_empty ? EmptyMark : to_result(rdata_rear);
    out_d.is_empty    = is_empty;
    out_d.is_full     = is_full;
    out_d.count       = CountW'(occ_q);
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cdq_pkg::*;

  localparam logic [2:0] ModeLast = 3'd7;  // highest of the unused codes, run as query
  localparam int NumRandom   = 2000;
  localparam int QuietTail   = 300;        // final beats with no idling on either side
  localparam int HoldAt      = 120;        // start the long output hold-off here
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 200000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  cdq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  cdq_out_t out_data_o;

  circular_deque_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicted deque contents and pointers
  word_t ring [Depth];
  int    front_idx;
  int    rear_idx;
  int    held;

  cdq_in_t  pending_ops[$];
  cdq_out_t deque_snapshots[$];
  int       n_items;
  int       beats_in;
  int       errors;
  logic     in_beat;

  int       send_gap;
  int       stall_left;
  int       hold_left;
  logic     hold_done;

  // Apply one operation to the predicted deque and return the view after it
  function automatic cdq_out_t deque_apply(cdq_in_t op);
    cdq_out_t r;
    r = '0;
    r.status = StatDone;
    case (op.mode)
      ModePushFront, ModePushRear: begin
        if (held >= Depth) begin
          r.status = StatOverflow;
        end else if (held == 0) begin
          // an empty deque restarts at entry zero
          front_idx = 0;
          rear_idx  = 0;
          ring[0]   = op.value[DataWidth-1:0];
          held      = 1;
        end else if (op.mode == ModePushFront) begin
          front_idx       = (front_idx == 0) ? Depth - 1 : front_idx - 1;
          ring[front_idx] = op.value[DataWidth-1:0];
          held++;
        end else begin
          rear_idx       = (rear_idx + 1) % Depth;
          ring[rear_idx] = op.value[DataWidth-1:0];
          held++;
        end
      end
      ModePopFront, ModePopRear: begin
        if (held == 0) begin
          r.status = StatUnderflow;
        end else if (held == 1) begin
          front_idx = 0;
          rear_idx  = 0;
          held      = 0;
        end else begin
          if (op.mode == ModePopFront) front_idx = (front_idx + 1) % Depth;
          else rear_idx = (rear_idx == 0) ? Depth - 1 : rear_idx - 1;
          held--;
        end
      end
      default: ;  // query and unused codes leave the deque alone
    endcase
    if (held == 0) begin
      r.front_value = EmptyMark;
      r.rear_value  = EmptyMark;
    end else begin
      r.front_value = 32'(signed'(ring[front_idx]));
      r.rear_value  = 32'(signed'(ring[rear_idx]));
    end
    r.is_empty = (held == 0);
    r.is_full  = (held >= Depth);
    r.count    = CountW'(held);
    return r;
  endfunction

  task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
               $time, field, want, want, got, got);
    end
  endtask

  // Monitor: sample both handshakes at the rising edge, check results, predict on input beats
  always @(posedge clk_i) begin
    cdq_out_t want;
    if (!rst_ni) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (deque_snapshots.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %p", $time, out_data_o);
        end else begin
          want = deque_snapshots.pop_front();
          check_field("status", want.status, out_data_o.status);
          check_field("front_value", want.front_value, out_data_o.front_value);
          check_field("rear_value", want.rear_value, out_data_o.rear_value);
          check_field("is_empty", want.is_empty, out_data_o.is_empty);
          check_field("is_full", want.is_full, out_data_o.is_full);
          check_field("count", want.count, out_data_o.count);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        deque_snapshots.push_back(deque_apply(in_data_i));
        beats_in++;
      end
    end
  end

  // Driver: hold a stalled beat, otherwise idle in bursts or present the next operation
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_beat) begin
        // hold: beat not taken yet
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (beats_in < n_items - QuietTail && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else begin
        in_data_i  <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // Receiver: one long hold-off to back the block up, then random stall bursts
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && beats_in >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (beats_in < n_items - QuietTail && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cdq_in_t op;
    int      seg_len;
    int      push_pct;
    int      roll;
    int      n_random;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    front_idx   = 0;
    rear_idx    = 0;
    held        = 0;
    beats_in    = 0;
    errors      = 0;
    send_gap    = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_done   = 1'b0;

    // Directed: empty deque first, then extremes, last-element pops, unused codes
    pending_ops.push_back('{mode: ModeQuery,     value: 32'sd0});
    pending_ops.push_back('{mode: ModePopFront,  value: 32'sd0});
    pending_ops.push_back('{mode: ModePopRear,   value: 32'sd0});
    pending_ops.push_back('{mode: ModePushRear,  value: 32'sh7FFFFFFF});
    pending_ops.push_back('{mode: ModePushFront, value: 32'sh80000000});
    pending_ops.push_back('{mode: ModePopFront,  value: 32'sh7FFFFFFF});
    pending_ops.push_back('{mode: ModePopRear,   value: 32'sh80000000});
    for (int k = 1; k <= 3; k++)
      pending_ops.push_back('{mode: 3'(ModeQuery + k), value: $urandom()});
    // Fill to the brim from both ends, starting with a front push into empty
    for (int k = 0; k < Depth; k++) begin
      op.mode = k[0] ? ModePushRear : ModePushFront;
      case (k % 4)
        0:       op.value = EmptyMark;
        1:       op.value = 32'sd0;
        2:       op.value = -32'sd1;
        default: op.value = $urandom();
      endcase
      pending_ops.push_back(op);
    end
    pending_ops.push_back('{mode: ModePushFront, value: 32'sh5A5A5A5A});
    pending_ops.push_back('{mode: ModePushRear,  value: 32'shA5A5A5A5});

    // Random: segments biased to fill, drain or mix, so full and empty are hit often
    n_random = 0;
    while (n_random < NumRandom) begin
      seg_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 20;
        default: push_pct = 46;
      endcase
      for (int k = 0; k < seg_len && n_random < NumRandom; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) op.mode = 3'($urandom_range(ModeQuery, ModeLast));
        else if (roll < 8 + push_pct) op.mode = 3'($urandom_range(ModePushFront, ModePushRear));
        else op.mode = 3'($urandom_range(ModePopFront, ModePopRear));
        case ($urandom_range(0, 15))
          0:       op.value = 32'sh7FFFFFFF;
          1:       op.value = 32'sh80000000;
          2:       op.value = -32'sd1;
          3:       op.value = 32'sd0;
          default: op.value = $urandom();
        endcase
        pending_ops.push_back(op);
        n_random++;
      end
    end
    n_items = pending_ops.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to go in, every result to come out, then a quiet tail
    while (beats_in != n_items) @(negedge clk_i);
    while (deque_snapshots.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
